// ===== rtl/kceq_pkg.sv =====
package kceq_pkg;

  localparam int unsigned QueueDepth = 16;
  localparam int unsigned NumKeys    = 3;
  localparam int unsigned KeyBitsW   = 3;
  localparam int unsigned OpcodeW    = 2;
  localparam int unsigned ButtonW    = 2;
  localparam int unsigned DropW      = 2;
  localparam int unsigned WatchKeys  = (NumKeys < KeyBitsW) ? NumKeys : KeyBitsW;
  localparam int unsigned KeyIdxW    = (WatchKeys > 1) ? $clog2(WatchKeys) : 1;
  localparam int unsigned PtrW       = $clog2(QueueDepth);

  typedef logic [PtrW-1:0]     ptr_t;
  typedef logic [KeyIdxW-1:0]  key_idx_t;
  typedef logic [ButtonW-1:0]  button_t;
  typedef logic [KeyBitsW-1:0] key_bits_t;
  typedef logic [OpcodeW-1:0]  opcode_t;
  typedef logic [DropW-1:0]    drop_t;

  typedef enum logic [OpcodeW-1:0] {
    OpSample = 2'd0,
    OpPower  = 2'd1,
    OpPop    = 2'd2
  } opcode_e;

  localparam button_t PowerButton = 2'd3;
  localparam key_idx_t LastKey    = key_idx_t'(WatchKeys - 1);

  typedef struct packed {
    logic    pressed;
    button_t button;
  } event_t;

  typedef struct packed {
    logic load;
    logic key_step;
    logic push_power;
    logic pop;
  } dp_cmd_t;

  typedef struct packed {
    logic key_last;
  } dp_status_t;

  function automatic ptr_t next_ptr(ptr_t p);
    ptr_t n;
    if (p == ptr_t'(QueueDepth - 1)) begin
      n = '0;
    end else begin
      n = p + ptr_t'(1);
    end
    return n;
  endfunction

endpackage

// ===== rtl/kceq_ctrl.sv =====
module kceq_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start,
  input  kceq_pkg::opcode_t      opcode_i,
  input  kceq_pkg::dp_status_t   status_i,
  output kceq_pkg::dp_cmd_t      cmd_o,
  output logic                   busy,
  output logic                   done_o
);

  typedef enum logic [4:0] {
    StIdle  = 5'b00001,
    StKey   = 5'b00010,
    StPower = 5'b00100,
    StPop   = 5'b01000,
    StDone  = 5'b10000
  } state_e;

  state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      StIdle: begin
        if (start) begin
          cmd_o.load = 1'b1;
          case (opcode_i)
            kceq_pkg::OpSample: state_d = StKey;
            kceq_pkg::OpPower:  state_d = StPower;
            kceq_pkg::OpPop:    state_d = StPop;
            default:            state_d = StDone;
          endcase
        end
      end
      StKey: begin
        cmd_o.key_step = 1'b1;
        if (status_i.key_last) begin
          state_d = StDone;
        end
      end
      StPower: begin
        cmd_o.push_power = 1'b1;
        state_d = StDone;
      end
      StPop: begin
        cmd_o.pop = 1'b1;
        state_d = StDone;
      end
      StDone: begin
        state_d = StIdle;
      end
      default: begin
        state_d = StIdle;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StIdle;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy   = (state_q != StIdle);
  assign done_o = (state_q == StDone);

endmodule

// ===== rtl/kceq_dp.sv =====
module kceq_dp (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  kceq_pkg::dp_cmd_t     cmd_i,
  input  kceq_pkg::key_bits_t   key_bits_i,
  output kceq_pkg::dp_status_t  status_o,
  output logic                  event_valid_o,
  output kceq_pkg::button_t     event_button_o,
  output logic                  event_pressed_o,
  output logic                  queue_not_empty_o,
  output kceq_pkg::drop_t       dropped_count_o
);

  kceq_pkg::event_t    mem_q [kceq_pkg::QueueDepth];
  kceq_pkg::event_t    rd_q;
  kceq_pkg::key_bits_t sample_q;
  kceq_pkg::key_bits_t lvl_q, lvl_d;
  kceq_pkg::key_idx_t  key_idx_q, key_idx_d;
  kceq_pkg::ptr_t      rptr_q, rptr_d;
  kceq_pkg::ptr_t      wptr_q, wptr_d;
  logic                valid_q, valid_d;
  kceq_pkg::drop_t     dropped_q, dropped_d;

  logic                key_now;
  logic                key_changed;
  logic                push_req;
  logic                full;
  logic                empty;
  logic                do_write;
  logic                do_read;
  kceq_pkg::event_t    push_evt;

  assign key_now     = sample_q[key_idx_q];
  assign key_changed = key_now != lvl_q[key_idx_q];
  assign push_req    = (cmd_i.key_step && key_changed) || cmd_i.push_power;
  assign full        = (kceq_pkg::next_ptr(wptr_q) == rptr_q);
  assign empty       = (rptr_q == wptr_q);
  assign do_write    = push_req && !full;
  assign do_read     = cmd_i.pop && !empty;

  always_comb begin
    if (cmd_i.key_step) begin
      push_evt.pressed = key_now;
      push_evt.button  = kceq_pkg::button_t'(key_idx_q);
    end else begin
      push_evt.pressed = 1'b1;
      push_evt.button  = kceq_pkg::PowerButton;
    end
  end

  always_comb begin
    lvl_d     = lvl_q;
    key_idx_d = key_idx_q;
    rptr_d    = rptr_q;
    wptr_d    = wptr_q;
    valid_d   = valid_q;
    dropped_d = dropped_q;
    if (cmd_i.load) begin
      key_idx_d = '0;
      valid_d   = 1'b0;
      dropped_d = '0;
    end
    if (cmd_i.key_step) begin
      lvl_d[key_idx_q] = key_now;
      key_idx_d = key_idx_q + kceq_pkg::key_idx_t'(1);
    end
    if (push_req && full) begin
      dropped_d = dropped_q + kceq_pkg::drop_t'(1);
    end
    if (do_write) begin
      wptr_d = kceq_pkg::next_ptr(wptr_q);
    end
    if (do_read) begin
      rptr_d  = kceq_pkg::next_ptr(rptr_q);
      valid_d = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lvl_q     <= '0;
      key_idx_q <= '0;
      rptr_q    <= '0;
      wptr_q    <= '0;
      valid_q   <= 1'b0;
      dropped_q <= '0;
    end else begin
      lvl_q     <= lvl_d;
      key_idx_q <= key_idx_d;
      rptr_q    <= rptr_d;
      wptr_q    <= wptr_d;
      valid_q   <= valid_d;
      dropped_q <= dropped_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      sample_q <= key_bits_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (do_write) begin
      mem_q[wptr_q] <= push_evt;
    end
    if (do_read) begin
      rd_q <= mem_q[rptr_q];
    end
  end

  assign status_o.key_last = (key_idx_q == kceq_pkg::LastKey);

  assign event_valid_o     = valid_q;
  assign event_button_o    = valid_q ? rd_q.button : '0;
  assign event_pressed_o   = valid_q & rd_q.pressed;
  assign queue_not_empty_o = !empty;
  assign dropped_count_o   = dropped_q;

endmodule

// ===== rtl/key_change_event_queue.sv =====
// Channel   Handshake       Payload
// command   start / busy    opcode_i, key_bits_i
// result    done_o          event_valid_o, event_button_o, event_pressed_o,
//                           queue_not_empty_o, dropped_count_o
//
// A key sample goes from accept through StKey to StDone, one key per cycle over the
// watched keys (min of NumKeys, KeyBitsW). Power and pop pass through StPower/StPop.
// One item at a time; busy stays high until the result cycle has passed.
// Reset clears pointers and key levels; the event store is never cleared.
// The result is shown for one cycle on done_o; the receiver cannot stall.
module key_change_event_queue (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start,
  output logic                busy,
  input  kceq_pkg::opcode_t   opcode_i,
  input  kceq_pkg::key_bits_t key_bits_i,
  output logic                done_o,
  output logic                event_valid_o,
  output kceq_pkg::button_t   event_button_o,
  output logic                event_pressed_o,
  output logic                queue_not_empty_o,
  output kceq_pkg::drop_t     dropped_count_o
);

  kceq_pkg::dp_cmd_t    cmd;
  kceq_pkg::dp_status_t status;

  kceq_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start    (start),
    .opcode_i (opcode_i),
    .status_i (status),
    .cmd_o    (cmd),
    .busy     (busy),
    .done_o   (done_o)
  );

  kceq_dp u_dp (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cmd_i             (cmd),
    .key_bits_i        (key_bits_i),
    .status_o          (status),
    .event_valid_o     (event_valid_o),
    .event_button_o    (event_button_o),
    .event_pressed_o   (event_pressed_o),
    .queue_not_empty_o (queue_not_empty_o),
    .dropped_count_o   (dropped_count_o)
  );

endmodule

// ===== rtl/kceq_checker.sv =====
module kceq_checker (
  input logic                clk_i,
  input logic                rst_ni,
  input logic                start,
  input logic                busy,
  input kceq_pkg::opcode_t   opcode_i,
  input logic                done_o,
  input logic                event_valid_o,
  input kceq_pkg::button_t   event_button_o,
  input logic                event_pressed_o,
  input kceq_pkg::drop_t     dropped_count_o
);

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  a_done_in_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> busy)
    else $error("result beat outside busy window");

  a_done_release: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !busy && !done_o)
    else $error("busy held after result beat");

  a_empty_fields: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && !event_valid_o |-> event_button_o == '0 && !event_pressed_o)
    else $error("event fields set without event");

  a_pop_no_drop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o && event_valid_o |-> dropped_count_o == '0 && $past(opcode_i, 2) ==
      kceq_pkg::OpPop)
    else $error("popped beat shows drops or wrong opcode");

endmodule

bind key_change_event_queue kceq_checker u_kceq_checker (.*);
